FILE: rtl/csim_pkg.sv
// Shared constants and types for the cosine similarity stream block.
package csim_pkg;

    localparam int ELEM_W          = 16;
    localparam int OUT_W           = 16;
    localparam int MAX_LEN_DEFAULT = 128;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CHUNK_W         = 16;
    localparam int FRAC_SHIFT      = 32;
    localparam int QUOT_W          = FRAC_SHIFT + 1;
    localparam int ROOT_W          = QUOT_W / 2 + 1;
    localparam int ROOT_REM_W      = ROOT_W + 3;
    localparam int DENOM_FLOOR     = 115;
    localparam int FLOOR_W         = 7;
    localparam int OUT_MAX         = 32767;

    typedef struct packed {
        logic not_empty;
        logic full;
    } csim_q_status_t;

endpackage

FILE: rtl/cosine_similarity_stream.sv
// Top level of the streaming cosine similarity block.
//
// The slave channel takes one element pair per request: tdata carries elem_a and
// elem_b, and tlast marks the final pair of the two vectors. The master channel
// returns one request per vector: tdata carries the similarity in signed Q1.15,
// tuser carries zero_norm and length_error.
// The front part takes one pair every cycle while its queue has room and keeps
// the dot product and both squared norms. A finished vector enters a two-entry
// queue, so the next vector streams in while the back part is still working.
// The back part handles one vector at a time through a shared multiplier that
// takes 16 bits per cycle, a restoring divider with one quotient bit per cycle
// and a square root unit with one root bit per cycle. A zero norm or a length
// error skips these units and goes straight to the output register. Vectors
// arriving faster than the back part finishes them fill the queue and tready
// then drops. A stalled master holds its result in the output register while
// the back part finishes the next vector. Reset clears the sums, the queue and
// the output valid flag; no pass over any store is needed.
module cosine_similarity_stream #(
    parameter int MAX_LEN = csim_pkg::MAX_LEN_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [2*csim_pkg::ELEM_W-1:0] s_tdata,   // [15:0] elem_a, [31:16] elem_b
    input  logic                          s_tlast,   // last_elem
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [csim_pkg::OUT_W-1:0]    m_tdata,   // [15:0] similarity
    output logic [1:0]                    m_tuser    // [0] zero_norm, [1] length_error
);
    import csim_pkg::*;

    // Entry holds the overflow mark, both norms and the signed dot product.
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int NW      = 2 * ELEM_W - 1 + CNT_W;
    localparam int SUM_W   = NW + 1;
    localparam int ENTRY_W = SUM_W + 2 * NW + 1;

    csim_q_status_t     q_status;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] push_data;
    logic [ENTRY_W-1:0] pop_data;

    csim_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    csim_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    csim_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .pop      (pop),
        .pop_data (pop_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: rtl/csim_front.sv
// Front part: takes element pairs, accumulates the sums and queues finished vectors.
module csim_front #(
    parameter int MAX_LEN = csim_pkg::MAX_LEN_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [2*csim_pkg::ELEM_W-1:0]          s_tdata,
    input  logic                                   s_tlast,
    input  csim_pkg::csim_q_status_t               q_status,
    output logic                                   push,
    output logic [2*(2*csim_pkg::ELEM_W-1+$clog2(MAX_LEN+1))+
                  (2*csim_pkg::ELEM_W+$clog2(MAX_LEN+1)):0] push_data
);
    import csim_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int NW    = 2 * ELEM_W - 1 + CNT_W;
    localparam int SUM_W = NW + 1;
    localparam int PROD_W = 2 * ELEM_W;

    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic signed [PROD_W-1:0] prod_ab;
    logic signed [PROD_W-1:0] prod_aa;
    logic signed [PROD_W-1:0] prod_bb;

    logic [SUM_W-1:0] dot_reg, dot_next, dot_upd;
    logic [NW-1:0]    na_reg, na_next, na_upd;
    logic [NW-1:0]    nb_reg, nb_next, nb_upd;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_upd;
    logic             ovf_reg, ovf_next, ovf_upd;
    logic             accept;
    logic             room;

    assign elem_a  = s_tdata[ELEM_W-1:0];
    assign elem_b  = s_tdata[2*ELEM_W-1:ELEM_W];
    assign prod_ab = elem_a * elem_b;
    assign prod_aa = elem_a * elem_a;
    assign prod_bb = elem_b * elem_b;

    // A last pair needs a queue slot, so the front waits while the queue is full.
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign room     = (cnt_reg != CNT_W'(MAX_LEN));

    always_comb begin
        dot_upd = dot_reg;
        na_upd  = na_reg;
        nb_upd  = nb_reg;
        cnt_upd = cnt_reg;
        ovf_upd = ovf_reg;
        if (room) begin
            dot_upd = dot_reg + {{(SUM_W-PROD_W){prod_ab[PROD_W-1]}}, prod_ab};
            na_upd  = na_reg + {{(NW-PROD_W){1'b0}}, prod_aa};
            nb_upd  = nb_reg + {{(NW-PROD_W){1'b0}}, prod_bb};
            cnt_upd = cnt_reg + CNT_W'(1);
        end else begin
            ovf_upd = 1'b1;
        end
    end

    always_comb begin
        dot_next  = dot_reg;
        na_next   = na_reg;
        nb_next   = nb_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        push      = 1'b0;
        push_data = {ovf_upd, nb_upd, na_upd, dot_upd};
        if (accept) begin
            if (s_tlast) begin
                push     = 1'b1;
                dot_next = '0;
                na_next  = '0;
                nb_next  = '0;
                cnt_next = '0;
                ovf_next = 1'b0;
            end else begin
                dot_next = dot_upd;
                na_next  = na_upd;
                nb_next  = nb_upd;
                cnt_next = cnt_upd;
                ovf_next = ovf_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            dot_reg <= dot_next;
            na_reg  <= na_next;
            nb_reg  <= nb_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

FILE: rtl/csim_queue.sv
// Short queue of finished vector sums between the front and back parts.
module csim_queue #(
    parameter int DATA_W = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  logic [DATA_W-1:0]        push_data,
    input  logic                     pop,
    output logic [DATA_W-1:0]        pop_data,
    output csim_pkg::csim_q_status_t status
);
    import csim_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0]  slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign status.full      = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign do_push  = push && !status.full;
    assign do_pop   = pop && status.not_empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + COUNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/csim_back.sv
// Back part: multiplies, divides and takes the square root to form the cosine result.
module csim_back #(
    parameter int MAX_LEN = csim_pkg::MAX_LEN_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  csim_pkg::csim_q_status_t               q_status,
    output logic                                   pop,
    input  logic [2*(2*csim_pkg::ELEM_W-1+$clog2(MAX_LEN+1))+
                  (2*csim_pkg::ELEM_W+$clog2(MAX_LEN+1)):0] pop_data,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [csim_pkg::OUT_W-1:0]             m_tdata,
    output logic [1:0]                             m_tuser
);
    import csim_pkg::*;

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int NW     = 2 * ELEM_W - 1 + CNT_W;
    localparam int SUM_W  = NW + 1;
    localparam int PW     = 2 * NW;
    localparam int NCH    = (NW + CHUNK_W - 1) / CHUNK_W;
    localparam int BW     = NCH * CHUNK_W;
    localparam int STEP_W = $clog2(((QUOT_W > NCH) ? QUOT_W : NCH) + 1);
    localparam int SQX_W  = 2 * ROOT_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL_P = 6'b000010,
        ST_MUL_D = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_SQRT  = 6'b010000,
        ST_DONE  = 6'b100000
    } csim_back_state_t;

    csim_back_state_t state_reg, state_next;

    logic [STEP_W-1:0]     step_reg, step_next;
    logic [NW-1:0]         mul_a_reg, mul_a_next;
    logic [BW-1:0]         mul_b_reg, mul_b_next;
    logic [PW-1:0]         acc_reg, acc_next;
    logic [PW-1:0]         p_reg, p_next;
    logic [NW-1:0]         mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [PW-1:0]         rem_reg, rem_next;
    logic [QUOT_W-1:0]     num_reg, num_next;
    logic [QUOT_W-1:0]     quot_reg, quot_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [ROOT_REM_W-1:0] sqrem_reg, sqrem_next;
    logic [SQX_W-1:0]      sqx_reg, sqx_next;
    logic                  zn_reg, zn_next;
    logic                  le_reg, le_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_sim_reg, out_sim_next;
    logic [1:0]            out_flags_reg, out_flags_next;

    // Queue entry fields
    logic signed [SUM_W-1:0] e_dot;
    logic [NW-1:0]           e_na, e_nb, e_mag;
    logic                    e_ovf, e_zero;
    logic [2*FLOOR_W-1:0]    small_prod;

    // Datapath terms
    logic [NW+CHUNK_W-1:0]   mul_prod;
    logic [PW-1:0]           acc_step;
    logic [PW:0]             div_trial;
    logic                    div_ge;
    logic [QUOT_W-1:0]       quot_step;
    logic [ROOT_REM_W+1:0]   sq_trial, sq_sub;
    logic                    sq_ge;
    logic [ROOT_W:0]         q_mag;
    logic [OUT_W-1:0]        sim_value;
    logic                    load_out;

    assign e_dot = pop_data[SUM_W-1:0];
    assign e_na  = pop_data[SUM_W+NW-1:SUM_W];
    assign e_nb  = pop_data[SUM_W+2*NW-1:SUM_W+NW];
    assign e_ovf = pop_data[SUM_W+2*NW];
    assign e_mag = e_dot[SUM_W-1] ? NW'(-e_dot) : NW'(e_dot);

    // Denominator at or below the floor: one norm is zero or the product is tiny.
    assign small_prod = e_na[FLOOR_W-1:0] * e_nb[FLOOR_W-1:0];
    assign e_zero = (e_na == '0) || (e_nb == '0) ||
                    ((e_na <= NW'(DENOM_FLOOR)) && (e_nb <= NW'(DENOM_FLOOR)) &&
                     (small_prod <= (2*FLOOR_W)'(DENOM_FLOOR)));

    // Shared multiplier: one chunk of the second operand per cycle, most significant first.
    assign mul_prod = mul_a_reg * mul_b_reg[BW-1 -: CHUNK_W];
    assign acc_step = (acc_reg << CHUNK_W) + PW'(mul_prod);

    // Restoring division step
    assign div_trial = {rem_reg, num_reg[QUOT_W-1]};
    assign div_ge    = (div_trial >= {1'b0, p_reg});
    assign quot_step = {quot_reg[QUOT_W-2:0], div_ge};

    // Square root step, two radicand bits per cycle
    assign sq_trial = {sqrem_reg, sqx_reg[SQX_W-1 -: 2]};
    assign sq_sub   = (ROOT_REM_W+2)'({root_reg, 2'b01});
    assign sq_ge    = (sq_trial >= sq_sub);

    // Round to nearest from the root of the scaled quotient, then saturate.
    assign q_mag = ({1'b0, root_reg} + (ROOT_W+1)'(1)) >> 1;
    assign sim_value = neg_reg ? OUT_W'(-q_mag) :
                       ((q_mag > (ROOT_W+1)'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(q_mag));

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        acc_next       = acc_reg;
        p_next         = p_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        quot_next      = quot_reg;
        root_next      = root_reg;
        sqrem_next     = sqrem_reg;
        sqx_next       = sqx_reg;
        zn_next        = zn_reg;
        le_next        = le_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_sim_next   = out_sim_reg;
        out_flags_next = out_flags_reg;

        case (state_reg)
            ST_IDLE: begin
                if (q_status.not_empty) begin
                    pop        = 1'b1;
                    le_next    = e_ovf;
                    zn_next    = !e_ovf && e_zero;
                    neg_next   = e_dot[SUM_W-1] && !e_ovf && !e_zero;
                    mag_next   = e_mag;
                    mul_a_next = e_na;
                    mul_b_next = BW'(e_nb);
                    acc_next   = '0;
                    root_next  = '0;
                    step_next  = STEP_W'(NCH);
                    state_next = (e_ovf || e_zero) ? ST_DONE : ST_MUL_P;
                end
            end
            ST_MUL_P: begin
                acc_next   = acc_step;
                mul_b_next = mul_b_reg << CHUNK_W;
                step_next  = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    p_next     = acc_step;
                    mul_a_next = mag_reg;
                    mul_b_next = BW'(mag_reg);
                    acc_next   = '0;
                    step_next  = STEP_W'(NCH);
                    state_next = ST_MUL_D;
                end
            end
            ST_MUL_D: begin
                acc_next   = acc_step;
                mul_b_next = mul_b_reg << CHUNK_W;
                step_next  = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    // Dividend is dot squared times 2^32; the top bits seed the remainder.
                    rem_next   = acc_step >> 1;
                    num_next   = {acc_step[0], {FRAC_SHIFT{1'b0}}};
                    quot_next  = '0;
                    step_next  = STEP_W'(QUOT_W);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = div_ge ? PW'(div_trial - {1'b0, p_reg}) : div_trial[PW-1:0];
                num_next  = num_reg << 1;
                quot_next = quot_step;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    sqx_next   = SQX_W'(quot_step);
                    sqrem_next = '0;
                    root_next  = '0;
                    step_next  = STEP_W'(ROOT_W);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                sqrem_next = sq_ge ? ROOT_REM_W'(sq_trial - sq_sub) : ROOT_REM_W'(sq_trial);
                root_next  = {root_reg[ROOT_W-2:0], sq_ge};
                sqx_next   = sqx_reg << 2;
                step_next  = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    out_valid_next = 1'b1;
                    out_sim_next   = sim_value;
                    out_flags_next = {le_reg, zn_reg};
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        step_reg      <= step_next;
        mul_a_reg     <= mul_a_next;
        mul_b_reg     <= mul_b_next;
        acc_reg       <= acc_next;
        p_reg         <= p_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        rem_reg       <= rem_next;
        num_reg       <= num_next;
        quot_reg      <= quot_next;
        root_reg      <= root_next;
        sqrem_reg     <= sqrem_next;
        sqx_reg       <= sqx_next;
        zn_reg        <= zn_next;
        le_reg        <= le_next;
        out_sim_reg   <= out_sim_next;
        out_flags_reg <= out_flags_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sim_reg;
    assign m_tuser  = out_flags_reg;

endmodule
